// ===== rtl/assert_macros.svh =====
// assertion macros for the timer queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DLTQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: label");
`define DLTQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`else
`define DLTQ_ASSERT_IMP(label, clk, rstn, ante, cons)
`define DLTQ_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/dltq_pkg.sv =====
// shared types and constants of the delta list timer queue
`default_nettype none
package dltq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int DELAY_BITS_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_NOP   = 2'd3
    } op_e_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_IGNORED   = 3'd1,
        ST_STOP_IDLE = 3'd2,
        ST_NO_EXPIRY = 3'd3,
        ST_EXPIRED   = 3'd4
    } status_e_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  timer_id;
        logic [15:0] delay_ticks;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  expired_id;
        logic [31:0] tick_total;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_START_WALK, S_INS_A, S_INS_B, S_STOP_WALK,
        S_STOP_ADD, S_TICK_DEC, S_TICK_EVAL, S_TICK_RD, S_TICK_FIN, S_RESPOND
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_ACCEPT, CMD_START_BEGIN, CMD_WALK_STEP, CMD_WALK_STOP,
        CMD_INS_A, CMD_INS_B, CMD_STOP_BEGIN, CMD_STOP_STEP, CMD_STOP_UNLINK,
        CMD_STOP_ADD, CMD_TICK_BEGIN, CMD_TICK_DEC, CMD_TICK_LOAD, CMD_TICK_TAKE
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t   op;
        logic      emit;
        logic      emit_pend;
        logic      last;
        status_e_t status;
    } ctrl_cmd_t;

    typedef struct packed {
        op_e_t op;
        logic  id_ok;
        logic  id_active;
        logic  head_valid;
        logic  rd_le;
        logic  rd_link_valid;
        logic  node_is_id;
        logic  ev_zero;
        logic  ev_link_valid;
        logic  n_lt_max;
        logic  pend_valid;
        logic  out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/dltq_ctrl.sv =====
// controller state machine of the timer queue
`default_nettype none
module dltq_ctrl import dltq_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t stat,
    output ctrl_cmd_t       cmd
);

    state_t    state_reg, state_next;
    status_e_t resp_reg, resp_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            resp_reg  <= ST_DONE;
        end else begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        resp_next     = resp_reg;
        cmd           = '0;
        cmd.op        = CMD_NONE;
        cmd.status    = ST_DONE;
        s_ready       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = CMD_ACCEPT;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (stat.op)
                    OP_TICK: begin
                        cmd.op     = CMD_TICK_BEGIN;
                        state_next = stat.head_valid ? S_TICK_DEC : S_TICK_FIN;
                    end
                    OP_START: begin
                        if (!stat.id_ok || stat.id_active) begin
                            resp_next  = ST_IGNORED;
                            state_next = S_RESPOND;
                        end else begin
                            cmd.op     = CMD_START_BEGIN;
                            state_next = stat.head_valid ? S_START_WALK : S_INS_A;
                        end
                    end
                    OP_STOP: begin
                        if (!stat.id_ok || !stat.id_active) begin
                            resp_next  = ST_STOP_IDLE;
                            state_next = S_RESPOND;
                        end else begin
                            cmd.op     = CMD_STOP_BEGIN;
                            state_next = S_STOP_WALK;
                        end
                    end
                    default: begin
                        resp_next  = ST_DONE;
                        state_next = S_RESPOND;
                    end
                endcase
            end
            S_START_WALK: begin
                if (stat.rd_le) begin
                    cmd.op = CMD_WALK_STEP;
                    if (!stat.rd_link_valid) state_next = S_INS_A;
                end else begin
                    cmd.op     = CMD_WALK_STOP;
                    state_next = S_INS_A;
                end
            end
            S_INS_A: begin
                cmd.op     = CMD_INS_A;
                state_next = S_INS_B;
            end
            S_INS_B: begin
                if (stat.out_free) begin
                    cmd.op     = CMD_INS_B;
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.status = ST_DONE;
                    state_next = S_IDLE;
                end
            end
            S_STOP_WALK: begin
                if (stat.node_is_id) begin
                    cmd.op    = CMD_STOP_UNLINK;
                    resp_next = ST_DONE;
                    state_next = stat.rd_link_valid ? S_STOP_ADD : S_RESPOND;
                end else begin
                    cmd.op = CMD_STOP_STEP;
                end
            end
            S_STOP_ADD: begin
                cmd.op     = CMD_STOP_ADD;
                state_next = S_RESPOND;
            end
            S_TICK_DEC: begin
                cmd.op     = CMD_TICK_DEC;
                state_next = S_TICK_EVAL;
            end
            S_TICK_EVAL: begin
                if (stat.ev_zero && stat.n_lt_max) begin
                    if (!stat.pend_valid || stat.out_free) begin
                        cmd.op        = CMD_TICK_TAKE;
                        cmd.emit      = stat.pend_valid;
                        cmd.emit_pend = 1'b1;
                        cmd.status    = ST_EXPIRED;
                        state_next    = stat.ev_link_valid ? S_TICK_RD : S_TICK_FIN;
                    end
                end else begin
                    state_next = S_TICK_FIN;
                end
            end
            S_TICK_RD: begin
                cmd.op     = CMD_TICK_LOAD;
                state_next = S_TICK_EVAL;
            end
            S_TICK_FIN: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.last      = 1'b1;
                    cmd.emit_pend = stat.pend_valid;
                    cmd.status    = stat.pend_valid ? ST_EXPIRED : ST_NO_EXPIRY;
                    state_next    = S_IDLE;
                end
            end
            S_RESPOND: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.status = resp_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/dltq_datapath.sv =====
// list memories, registers and result register of the timer queue
`default_nettype none
module dltq_datapath import dltq_pkg::*; #(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int DELAY_BITS = DELAY_BITS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire in_item_t  s_data,
    input  wire ctrl_cmd_t cmd,
    output dp_status_t     stat,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int LW = $clog2(NUM_TIMERS + 1);
    localparam int DW = DELAY_BITS + 1;
    localparam logic [LW-1:0] NO_LINK = LW'(NUM_TIMERS);
    localparam logic [31:0] DMASK = (32'd1 << DELAY_BITS) - 32'd1;

    // list memories
    logic [DW-1:0] delta_mem [NUM_TIMERS];
    logic [LW-1:0] link_mem  [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] active_reg, active_next;

    logic [1:0]      op_reg;
    logic [3:0]      id_reg;
    logic [DW-1:0]   t_reg, t_next;
    logic [LW-1:0]   head_reg, head_next;
    logic [LW-1:0]   node_reg, node_next;
    logic [LW-1:0]   prev_reg, prev_next;
    logic [DW-1:0]   fdelta_reg, fdelta_next;
    logic [DW-1:0]   ev_delta_reg, ev_delta_next;
    logic [LW-1:0]   ev_link_reg, ev_link_next;
    logic [LW-1:0]   pend_reg, pend_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [31:0]     tick_reg, tick_next;
    logic [DW-1:0]   rd_delta_reg;
    logic [LW-1:0]   rd_link_reg;
    logic            m_valid_reg;
    out_item_t       out_reg;

    logic          rd_en;
    logic [LW-1:0] rd_addr;
    logic          dwe, lwe;
    logic [LW-1:0] dwaddr, lwaddr;
    logic [DW-1:0] dwdata;
    logic [LW-1:0] lwdata;
    logic [IW-1:0] id_idx;
    logic [LW-1:0] id_link;
    logic [DW-1:0] dec_val;
    logic          out_free;

    assign id_idx   = IW'(id_reg);
    assign id_link  = LW'(id_reg);
    assign dec_val  = (rd_delta_reg == '0) ? '0 : rd_delta_reg - DW'(1);
    assign out_free = !m_valid_reg || m_ready;

    // status to the controller
    always_comb begin
        stat.op            = op_e_t'(op_reg);
        stat.id_ok         = 32'(id_reg) < NUM_TIMERS;
        stat.id_active     = stat.id_ok && active_reg[id_idx];
        stat.head_valid    = head_reg != NO_LINK;
        stat.rd_le         = rd_delta_reg <= t_reg;
        stat.rd_link_valid = rd_link_reg != NO_LINK;
        stat.node_is_id    = node_reg == id_link;
        stat.ev_zero       = ev_delta_reg == '0;
        stat.ev_link_valid = ev_link_reg != NO_LINK;
        stat.n_lt_max      = 32'(n_reg) < MAX_RESULTS;
        stat.pend_valid    = n_reg != '0;
        stat.out_free      = out_free;
    end

    // command decode
    always_comb begin
        t_next        = t_reg;
        head_next     = head_reg;
        node_next     = node_reg;
        prev_next     = prev_reg;
        fdelta_next   = fdelta_reg;
        ev_delta_next = ev_delta_reg;
        ev_link_next  = ev_link_reg;
        pend_next     = pend_reg;
        n_next        = n_reg;
        tick_next     = tick_reg;
        active_next   = active_reg;
        rd_en   = 1'b0;
        rd_addr = head_reg;
        dwe     = 1'b0;
        dwaddr  = node_reg;
        dwdata  = fdelta_reg;
        lwe     = 1'b0;
        lwaddr  = prev_reg;
        lwdata  = id_link;
        case (cmd.op)
            CMD_ACCEPT: begin
                t_next = DW'(32'(s_data.delay_ticks) & DMASK) + DW'(1);
            end
            CMD_START_BEGIN, CMD_STOP_BEGIN: begin
                node_next = head_reg;
                prev_next = NO_LINK;
                rd_en     = 1'b1;
                rd_addr   = head_reg;
            end
            CMD_WALK_STEP: begin
                t_next    = t_reg - rd_delta_reg;
                prev_next = node_reg;
                node_next = rd_link_reg;
                rd_en     = 1'b1;
                rd_addr   = rd_link_reg;
            end
            CMD_WALK_STOP: begin
                fdelta_next = rd_delta_reg - t_reg;
            end
            CMD_INS_A: begin
                dwe    = 1'b1;
                dwaddr = id_link;
                dwdata = t_reg;
                lwe    = 1'b1;
                lwaddr = id_link;
                lwdata = node_reg;
            end
            CMD_INS_B: begin
                dwe    = node_reg != NO_LINK;
                dwaddr = node_reg;
                dwdata = fdelta_reg;
                lwe    = prev_reg != NO_LINK;
                lwaddr = prev_reg;
                lwdata = id_link;
                if (prev_reg == NO_LINK) head_next = id_link;
                active_next[id_idx] = 1'b1;
            end
            CMD_STOP_STEP: begin
                prev_next = node_reg;
                node_next = rd_link_reg;
                rd_en     = 1'b1;
                rd_addr   = rd_link_reg;
            end
            CMD_STOP_UNLINK: begin
                fdelta_next = rd_delta_reg;
                node_next   = rd_link_reg;
                lwe    = prev_reg != NO_LINK;
                lwaddr = prev_reg;
                lwdata = rd_link_reg;
                if (prev_reg == NO_LINK) head_next = rd_link_reg;
                active_next[id_idx] = 1'b0;
                rd_en   = 1'b1;
                rd_addr = rd_link_reg;
            end
            CMD_STOP_ADD: begin
                dwe    = 1'b1;
                dwaddr = node_reg;
                dwdata = rd_delta_reg + fdelta_reg;
            end
            CMD_TICK_BEGIN: begin
                tick_next = tick_reg + 32'd1;
                n_next    = '0;
                rd_en     = 1'b1;
                rd_addr   = head_reg;
            end
            CMD_TICK_DEC: begin
                dwe           = 1'b1;
                dwaddr        = head_reg;
                dwdata        = dec_val;
                ev_delta_next = dec_val;
                ev_link_next  = rd_link_reg;
            end
            CMD_TICK_LOAD: begin
                ev_delta_next = rd_delta_reg;
                ev_link_next  = rd_link_reg;
            end
            CMD_TICK_TAKE: begin
                pend_next = head_reg;
                head_next = ev_link_reg;
                n_next    = n_reg + CNT_W'(1);
                active_next[head_reg[IW-1:0]] = 1'b0;
                rd_en   = 1'b1;
                rd_addr = ev_link_reg;
            end
            default: ;
        endcase
    end

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (dwe) delta_mem[dwaddr[IW-1:0]] <= dwdata;
        if (lwe) link_mem[lwaddr[IW-1:0]] <= lwdata;
        if (rd_en) begin
            rd_delta_reg <= delta_mem[rd_addr[IW-1:0]];
            rd_link_reg  <= link_mem[rd_addr[IW-1:0]];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= '0;
            head_reg    <= NO_LINK;
            tick_reg    <= '0;
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            head_reg   <= head_next;
            tick_reg   <= tick_next;
            n_reg      <= n_next;
            if (cmd.emit) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        if (cmd.op == CMD_ACCEPT) begin
            op_reg <= s_data.op;
            id_reg <= s_data.timer_id;
        end
        t_reg        <= t_next;
        node_reg     <= node_next;
        prev_reg     <= prev_next;
        fdelta_reg   <= fdelta_next;
        ev_delta_reg <= ev_delta_next;
        ev_link_reg  <= ev_link_next;
        pend_reg     <= pend_next;
        if (cmd.emit) begin
            out_reg.status     <= cmd.status;
            out_reg.expired_id <= cmd.emit_pend ? 4'(pend_reg) : id_reg;
            out_reg.tick_total <= tick_reg;
            out_reg.last       <= cmd.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

// ===== rtl/delta_list_timer_queue.sv =====
// top level of the delta list timer queue
// One item at a time: s_ready is high only while the block is idle.
// - start: walks the list to its place, then writes the entry and its follower.
// - stop: walks the list up to the timer, unlinks it and adds its delta on.
// - tick on an empty list: counts the tick and reports no expiry.
// - tick otherwise: decrements the head delta, then takes each expired timer
//   from the head, up to MAX_RESULTS per tick.
// A result may be held by m_ready. The walk reads one list entry per cycle from
// the single read port of the delta and link memories. Results leave through an
// output register, so one pending result may wait on m_ready while the next list
// step runs. No clearing pass after reset: only the per-timer active bits, the
// list head, the tick count, the result count and the output valid are reset.
`default_nettype none
`include "assert_macros.svh"
module delta_list_timer_queue import dltq_pkg::*; #(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int DELAY_BITS = DELAY_BITS_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    // controller
    dltq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath
    dltq_datapath #(
        .NUM_TIMERS (NUM_TIMERS),
        .DELAY_BITS (DELAY_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // checks
    `DLTQ_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready)
    `DLTQ_ASSERT_IMP(a_emit_free, aclk, aresetn, cmd.emit, stat.out_free)
    `DLTQ_ASSERT_IMP(a_take_bound, aclk, aresetn, cmd.op == CMD_TICK_TAKE, stat.n_lt_max)

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench of the delta list timer queue
`default_nettype none
module testbench;
    import dltq_pkg::*;

    localparam int NTIM = 16;
    localparam int CYCLE_LIMIT = 400000;

    // scoreboard: a model of the timer list and the queue of expected results
    class timer_scoreboard;
        bit        armed[NTIM];
        bit [16:0] delta[NTIM];
        int        link[NTIM];
        int        head;
        bit [31:0] ticks;
        out_item_t expected_q[$];
        int        errors;

        function void clear();
            for (int i = 0; i < NTIM; i++) begin
                armed[i] = 0;
                delta[i] = 0;
                link[i] = NTIM;
            end
            head = NTIM;
            ticks = 0;
            errors = 0;
        endfunction

        function void push(status_e_t st, bit [3:0] id, bit lst);
            out_item_t r;
            r.status = st;
            r.expired_id = id;
            r.tick_total = ticks;
            r.last = lst;
            expected_q.push_back(r);
        endfunction

        // note an accepted input and queue its results
        function void note_input(in_item_t it);
            int node, prev, fol, n;
            bit [16:0] t;
            n = 0;
            case (op_e_t'(it.op))
                OP_START: begin
                    if (armed[it.timer_id]) begin
                        push(ST_IGNORED, it.timer_id, 1);
                    end else begin
                        t = {1'b0, it.delay_ticks} + 17'd1;
                        prev = NTIM;
                        node = head;
                        while (node < NTIM && delta[node] <= t) begin
                            t -= delta[node];
                            prev = node;
                            node = link[node];
                        end
                        delta[it.timer_id] = t;
                        if (node < NTIM) delta[node] -= t;
                        link[it.timer_id] = node;
                        if (prev < NTIM) link[prev] = it.timer_id;
                        else head = it.timer_id;
                        armed[it.timer_id] = 1;
                        push(ST_DONE, it.timer_id, 1);
                    end
                end
                OP_STOP: begin
                    if (!armed[it.timer_id]) begin
                        push(ST_STOP_IDLE, it.timer_id, 1);
                    end else begin
                        prev = NTIM;
                        node = head;
                        while (node < NTIM && node != it.timer_id) begin
                            prev = node;
                            node = link[node];
                        end
                        fol = link[it.timer_id];
                        if (prev < NTIM) link[prev] = fol;
                        else head = fol;
                        if (fol < NTIM) delta[fol] += delta[it.timer_id];
                        armed[it.timer_id] = 0;
                        push(ST_DONE, it.timer_id, 1);
                    end
                end
                OP_NOP: push(ST_DONE, it.timer_id, 1);
                default: begin
                    ticks++;
                    if (head < NTIM && delta[head] > 0) delta[head]--;
                    while (n < MAX_RESULTS && head < NTIM && delta[head] == 0) begin
                        armed[head] = 0;
                        push(ST_EXPIRED, head[3:0], 0);
                        head = link[head];
                        n++;
                    end
                    if (n == 0) push(ST_NO_EXPIRY, it.timer_id, 1);
                    else expected_q[$].last = 1;
                end
            endcase
        endfunction

        // compare an accepted result with the oldest expectation
        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.status !== exp_r.status) begin
                $display("%0t: status expected %0d actual %0d", $time,
                         exp_r.status, got.status);
                errors++;
            end
            if (got.expired_id !== exp_r.expired_id) begin
                $display("%0t: expired_id expected %0d actual %0d", $time,
                         exp_r.expired_id, got.expired_id);
                errors++;
            end
            if (got.tick_total !== exp_r.tick_total) begin
                $display("%0t: tick_total expected %0d actual %0d", $time,
                         exp_r.tick_total, got.tick_total);
                errors++;
            end
            if (got.last !== exp_r.last) begin
                $display("%0t: last expected %0d actual %0d", $time,
                         exp_r.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic      aclk = 0;
    logic      aresetn = 0;
    logic      s_valid = 0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 0;
    out_item_t m_data;

    timer_scoreboard board;
    bit  quiet = 0;
    int  cycles = 0;

    delta_list_timer_queue i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // clock
    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // result side: check transfers and stall in random bursts
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) board.check_result(m_data);
            if (hold > 0) begin
                hold--;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
                if (!quiet && $urandom_range(0, 9) == 0) hold = $urandom_range(1, 15);
            end
        end
    end

    // cycle limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // send one item, with an optional random gap first
    task automatic send_item(op_e_t op, bit [3:0] id, bit [15:0] dly);
        in_item_t it;
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge aclk);
        end
        it.op = op;
        it.timer_id = id;
        it.delay_ticks = dly;
        s_valid <= 1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        board.note_input(it);
        s_valid <= 0;
        // the block is busy after a transfer
        @(posedge aclk);
    endtask

    task automatic drain();
        while (board.expected_q.size() != 0) @(posedge aclk);
    endtask

    // random delay: mostly short so timers expire, sometimes any value
    function automatic bit [15:0] pick_delay();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'hffff;
            2: return 16'd0;
            default: return 16'($urandom_range(0, 12));
        endcase
    endfunction

    initial begin
        int r;
        board = new();
        board.clear();
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: idle tick, stop of idle, nop, extremes, ties, double start
        send_item(OP_TICK, 4'd0, 16'h0);
        send_item(OP_STOP, 4'd15, 16'h0);
        send_item(OP_NOP, 4'd9, 16'hffff);
        send_item(OP_START, 4'd15, 16'hffff);
        send_item(OP_START, 4'd0, 16'd0);
        send_item(OP_START, 4'd0, 16'd5);
        send_item(OP_START, 4'd1, 16'd2);
        send_item(OP_START, 4'd2, 16'd2);
        send_item(OP_START, 4'd3, 16'd1);
        send_item(OP_STOP, 4'd2, 16'h0);
        send_item(OP_STOP, 4'd15, 16'h0);
        for (int i = 0; i < 4; i++) send_item(OP_TICK, 4'($urandom), 16'($urandom));
        // all sixteen timers expiring on one tick
        for (int i = 0; i < NTIM; i++) send_item(OP_START, 4'(i), 16'd0);
        send_item(OP_TICK, 4'd5, 16'h0);
        drain();

        // random part: roughly half ticks so the list keeps turning over
        for (int i = 0; i < 200; i++) begin
            if (i == 100) drain();
            if (i == 170) quiet = 1;
            r = $urandom_range(0, 19);
            if (r < 9) send_item(OP_TICK, 4'($urandom), 16'($urandom));
            else if (r < 15) send_item(OP_START, 4'($urandom), pick_delay());
            else if (r < 19) send_item(OP_STOP, 4'($urandom), 16'($urandom));
            else send_item(OP_NOP, 4'($urandom), 16'($urandom));
        end

        drain();
        repeat (50) @(posedge aclk);
        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== delta_list_timer_queue.f =====
+incdir+rtl
rtl/dltq_pkg.sv
rtl/dltq_ctrl.sv
rtl/dltq_datapath.sv
rtl/delta_list_timer_queue.sv
test/testbench.sv
